// ----- rtl/rs_generator_poly_builder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the generator polynomial builder
// Immediate-implication and next-cycle-implication forms
// ----------------------------------------------------------------------------
`ifndef RS_GENERATOR_POLY_BUILDER_MACROS_SVH
`define RS_GENERATOR_POLY_BUILDER_MACROS_SVH

// consequent in the same cycle
`define RSGP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsgp check failed");

// consequent in the following cycle
`define RSGP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsgp check failed");

`endif

// ----- rtl/rsgp_pkg.sv -----
// ----------------------------------------------------------------------------
// rsgp_pkg
// Shared widths, codes, control types and GF(256) multiply
// ----------------------------------------------------------------------------
package rsgp_pkg;

   localparam int MAX_COEFFS_DEF = 63;
   localparam int IDX_W          = 6;
   localparam int COEF_W         = 8;
   localparam int DELTA_W        = 5;
   localparam int POLY_W         = 9;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_DELTA      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_POLY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIM_ELEM  = 2'd2;

   localparam logic [DELTA_W-1:0] DELTA_RST      = 5'd15;
   localparam logic [COEF_W-1:0]  FIELD_RED_RST  = 8'h1d;
   localparam logic [COEF_W-1:0]  PRIM_ELEM_RST  = 8'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic build;
      logic shift;
   } cell_ctrl_type;

   function automatic logic [COEF_W-1:0] gf_mul(
      input logic [COEF_W-1:0] a,
      input logic [COEF_W-1:0] b,
      input logic [COEF_W-1:0] red
   );
      logic [COEF_W-1:0] acc;
      logic [COEF_W-1:0] sh;
      acc = '0;
      sh  = a;
      for (int k = 0; k < COEF_W; k++) begin
         if (b[k]) begin
            acc = acc ^ sh;
         end
         sh = sh[COEF_W-1] ? ({sh[COEF_W-2:0], 1'b0} ^ red) : {sh[COEF_W-2:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

// ----- rtl/rs_generator_poly_builder.sv -----
// ----------------------------------------------------------------------------
// rs_generator_poly_builder
// Builds g(x) = (x - a^1)...(x - a^(2*delta)) over GF(256) in a chain of cells.
// Sequence: a seed step, then one build step per root (roots = min(2*delta, MAX_COEFFS-1)),
// then one word per cycle while rsp_stall is low for roots+1 coefficients, constant term first.
// Requests: a new request is taken only in idle (req_stall low), so the root loop and the
// word output must finish first; each output stall holds the current word.
// Reset: synchronous, clears control and loads delta 15, poly 0x11d, element 2.
// ----------------------------------------------------------------------------
module rs_generator_poly_builder
   import rsgp_pkg::*;
#(
   parameter int MAX_COEFFS = MAX_COEFFS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_req,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_W-1:0]      rsp_coef_index,
   output logic [COEF_W-1:0]     rsp_coef_value,
   output logic                  rsp_last,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [IDX_W-1:0] MAX_ROOTS = IDX_W'(MAX_COEFFS - 1);

   logic [DELTA_W-1:0] delta_ff;
   logic [COEF_W-1:0]  red_ff;
   logic [COEF_W-1:0]  prim_ff;

   state_type          state_ff;
   state_type          state_in;
   logic [IDX_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   cnt_in;
   logic [IDX_W-1:0]   cnt_inc;
   logic [IDX_W-1:0]   roots_ff;
   logic [IDX_W-1:0]   roots_in;
   logic [IDX_W-1:0]   roots_calc;
   logic [COEF_W-1:0]  root_ff;
   logic [COEF_W-1:0]  root_in;
   logic               start_go;
   logic               build_done;
   logic               emit_done;
   cell_ctrl_type      ctrl;
   logic [COEF_W-1:0]  coef [MAX_COEFFS];

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= DELTA_RST;
         red_ff   <= FIELD_RED_RST;
         prim_ff  <= PRIM_ELEM_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DELTA:      delta_ff <= csr_wdata[DELTA_W-1:0];
            CSR_FIELD_POLY: red_ff   <= csr_wdata[COEF_W-1:0];
            CSR_PRIM_ELEM:  prim_ff  <= csr_wdata[COEF_W-1:0];
            default:        ;
         endcase
      end
   end

   assign roots_calc = {delta_ff, 1'b0};
   assign cnt_inc    = cnt_ff + IDX_W'(1);
   assign start_go   = req_valid && req_start_req;
   assign build_done = (cnt_inc == roots_ff);
   assign emit_done  = !rsp_stall && (cnt_ff == roots_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_go) begin
               state_in = (roots_in == '0) ? ST_EMIT : ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (build_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      ctrl      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            ctrl.clear = start_go;
         end
         ST_BUILD: begin
            ctrl.build = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid  = 1'b1;
            ctrl.shift = !rsp_stall;
         end
         default: ;
      endcase
   end

   // counters and root
   always_comb begin
      cnt_in   = cnt_ff;
      roots_in = roots_ff;
      root_in  = root_ff;
      case (state_ff)
         ST_IDLE: begin
            roots_in = (roots_calc > MAX_ROOTS) ? MAX_ROOTS : roots_calc;
            if (start_go) begin
               cnt_in  = '0;
               root_in = prim_ff;
            end else begin
               roots_in = roots_ff;
            end
         end
         ST_BUILD: begin
            root_in = gf_mul(root_ff, prim_ff, red_ff);
            cnt_in  = build_done ? '0 : cnt_inc;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cnt_in = cnt_inc;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         roots_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         roots_ff <= roots_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   for (genvar i = 0; i < MAX_COEFFS; i++) begin : g_cell
      logic [COEF_W-1:0] prev_coef;
      logic [COEF_W-1:0] next_coef;
      if (i == 0) begin : g_head
         assign prev_coef = '0;
      end else begin : g_body
         assign prev_coef = coef[i-1];
      end
      if (i == MAX_COEFFS - 1) begin : g_tail
         assign next_coef = '0;
      end else begin : g_mid
         assign next_coef = coef[i+1];
      end
      rsgp_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .seed      (i == 0),
         .root      (root_ff),
         .red       (red_ff),
         .prev_coef (prev_coef),
         .next_coef (next_coef),
         .coef      (coef[i])
      );
   end

   assign rsp_coef_index = cnt_ff;
   assign rsp_coef_value = coef[0];
   assign rsp_last       = (cnt_ff == roots_ff);

endmodule

// ----- rtl/rsgp_cell.sv -----
// ----------------------------------------------------------------------------
// rsgp_cell
// One coefficient of the chain: seed, multiply-accumulate root step, shift out
// ----------------------------------------------------------------------------
module rsgp_cell
   import rsgp_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic              seed,
   input  logic [COEF_W-1:0] root,
   input  logic [COEF_W-1:0] red,
   input  logic [COEF_W-1:0] prev_coef,
   input  logic [COEF_W-1:0] next_coef,
   output logic [COEF_W-1:0] coef
);

   logic [COEF_W-1:0] coef_ff;
   logic [COEF_W-1:0] coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (ctrl.clear) begin
         coef_in = {{(COEF_W-1){1'b0}}, seed};
      end else if (ctrl.build) begin
         coef_in = gf_mul(coef_ff, root, red) ^ prev_coef;
      end else if (ctrl.shift) begin
         coef_in = next_coef;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

// ----- rtl/rsgp_checker.sv -----
// ----------------------------------------------------------------------------
// rsgp_checker
// Port-level checks on the builder, bound to the top level
// ----------------------------------------------------------------------------
`include "rs_generator_poly_builder_macros.svh"

module rsgp_checker
   import rsgp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [IDX_W-1:0]      rsp_coef_index,
   input logic [COEF_W-1:0]     rsp_coef_value,
   input logic                  rsp_last
);

   `RSGP_ASSERT_SAME(a_busy_emit, clock, reset, rsp_valid, req_stall)
   `RSGP_ASSERT_SAME(a_last_monic, clock, reset, rsp_valid && rsp_last, rsp_coef_value == 8'd1)
   `RSGP_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last,
      rsp_valid && rsp_coef_index == $past(rsp_coef_index) + 6'd1)
   `RSGP_ASSERT_NEXT(a_end_idle, clock, reset, rsp_valid && !rsp_stall && rsp_last,
      !rsp_valid && !req_stall)
   `RSGP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_coef_index) && $stable(rsp_coef_value))

endmodule

bind rs_generator_poly_builder rsgp_checker u_rsgp_checker (.*);
